/* sv/spct_pkg.sv */
// Shared codes for the shape pair collision tester.
// No dependencies; imported by the top level and the segment unit.
package spct_pkg;

  // Test selector codes carried by each input word
  typedef enum logic [3:0] {
    FN_RR_OVL = 4'd0,
    FN_RC_OVL = 4'd1,
    FN_RS_OVL = 4'd2,
    FN_RP_OVL = 4'd3,
    FN_CC_OVL = 4'd4,
    FN_CS_OVL = 4'd5,
    FN_CP_OVL = 4'd6,
    FN_SS_OVL = 4'd7,
    FN_RR_CON = 4'd8,
    FN_RC_CON = 4'd9,
    FN_RS_CON = 4'd10,
    FN_CC_CON = 4'd11,
    FN_CR_CON = 4'd12,
    FN_CS_CON = 4'd13
  } func_t;

  // Cross product magnitudes at or above this bit position count as a miss
  localparam int CROSS_LIMIT_BITS = 64;
  // Interior circle-segment compare is done modulo this many bits
  localparam int CMP_LIMIT_BITS = 128;

endpackage

/* sv/spct_seg_unit.sv */
// Pipelined segment-segment intersection test (four register stages).
// Depends on spct_pkg; instantiated by shape_pair_collision_test_unit.
module spct_seg_unit import spct_pkg::*; #(
  parameter int OW = 19
) (
  input  logic                 clk,
  input  logic [3:0]           adv,
  input  logic signed [OW-1:0] ax,
  input  logic signed [OW-1:0] ay,
  input  logic signed [OW-1:0] bx,
  input  logic signed [OW-1:0] by,
  input  logic signed [OW-1:0] cx,
  input  logic signed [OW-1:0] cy,
  input  logic signed [OW-1:0] dx,
  input  logic signed [OW-1:0] dy,
  output logic                 hit
);

  localparam int PW = 2 * OW;
  localparam int SW = PW + 1;

  logic signed [OW-1:0] e1_r, e2_r, f1_r, f2_r, g1_r, g2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [SW-1:0] d_r, na_r, nb_r;
  logic                 hit_r, hit_nxt;

  // n / d lies in [0, 1]
  function automatic logic in_unit(input logic signed [SW-1:0] n,
                                   input logic signed [SW-1:0] d);
    logic res;
    if (d >= 0) begin
      res = (n >= 0) && (n <= d);
    end else begin
      res = (n <= 0) && (n >= d);
    end
    return res;
  endfunction

  // Direction and offset vectors
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      e1_r <= bx - ax;
      e2_r <= by - ay;
      f1_r <= dx - cx;
      f2_r <= dy - cy;
      g1_r <= ax - cx;
      g2_r <= ay - cy;
    end
  end

  // Cross products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p0_r <= PW'(f2_r) * PW'(e1_r);
      p1_r <= PW'(f1_r) * PW'(e2_r);
      p2_r <= PW'(f1_r) * PW'(g2_r);
      p3_r <= PW'(f2_r) * PW'(g1_r);
      p4_r <= PW'(e1_r) * PW'(g2_r);
      p5_r <= PW'(e2_r) * PW'(g1_r);
    end
  end

  // Denominator and the two numerators
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d_r  <= SW'(p0_r) - SW'(p1_r);
      na_r <= SW'(p2_r) - SW'(p3_r);
      nb_r <= SW'(p4_r) - SW'(p5_r);
    end
  end

  // Parallel or collinear segments are always reported as no hit
  always_comb begin
    hit_nxt = (d_r != '0) && in_unit(na_r, d_r) && in_unit(nb_r, d_r);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

/* sv/shape_pair_collision_test_unit.sv */
// Shape pair collision tester, top level: input registers, arithmetic pipeline, output stage.
// Depends on spct_pkg and spct_seg_unit.
//
// Takes one word per clock while the output is not stalled and returns one hit bit per word,
// in order. The eight register stages are: sign extension and corner sums, simple compares
// and operand selection, products, sums of products, distance and segment compares,
// partial products of the wide circle-segment compare, their sum, and the final select
// into the output register. Each stage holds its own valid bit and moves on when the
// stage after it is empty or moving, so bubbles close up and a stalled output holds the
// pipeline without loss. All compares are exact integer cross-multiplied forms;
// COORD_WIDTH sets how many low bits of each field are used.
module shape_pair_collision_test_unit import spct_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_func,
  input  logic signed [15:0] in_first_p0,
  input  logic signed [15:0] in_first_p1,
  input  logic signed [15:0] in_first_p2,
  input  logic signed [15:0] in_first_p3,
  input  logic signed [15:0] in_second_p0,
  input  logic signed [15:0] in_second_p1,
  input  logic signed [15:0] in_second_p2,
  input  logic signed [15:0] in_second_p3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit
);

  localparam int W    = COORD_WIDTH;
  localparam int OW   = W + 3;
  localparam int PW   = 2 * OW;
  localparam int SW   = PW + 1;
  localparam int MW   = PW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int BW   = 2 * MW;
  localparam int CMPW = (BW > CMP_LIMIT_BITS) ? CMP_LIMIT_BITS : BW;
  localparam int NS   = 8;

  typedef logic signed [OW-1:0] opd_t;
  typedef logic signed [W:0]    sum_t;

  typedef struct packed {
    logic       dir;
    logic       wa;
    logic       wb;
    logic       lenz;
    logic       dle0;
    logic       dge;
    logic       crovf;
    logic [3:0] seg;
  } flg_t;

  // Stage handshake
  logic [NS:1]   v_r;
  logic [NS+1:1] en;

  // Stage 1
  logic signed [15:0]  fin [4];
  logic signed [15:0]  sin [4];
  logic signed [31:0]  fext [4];
  logic signed [31:0]  sext [4];
  logic signed [W-1:0] a_nxt [4];
  logic signed [W-1:0] b_nxt [4];
  logic signed [W-1:0] a_r [4];
  logic signed [W-1:0] b_r [4];
  func_t fn1_r, fn2_r, fn3_r, fn4_r, fn5_r, fn6_r, fn7_r, fn8_r;
  sum_t ax1_r, ay1_r, bx1_r, by1_r, bxm_r, bym_r, byp_r, rsum_r, rdif_r;

  // Stage 2
  logic dir_nxt, dir2_r, dir3_r, dir4_r;
  logic rp0, rp1;
  sum_t nx_t, ny_t, nx, ny;
  opd_t dxa_nxt, dya_nxt, ra_nxt, dxb_nxt, dyb_nxt, rb_nxt;
  opd_t dxa_r, dya_r, ra_r, dxb_r, dyb_r, rb_r;
  opd_t abx_r, aby_r, acx_r, acy_r;
  opd_t sga [4][8];
  logic [3:0] seg_hit;

  // Stage 3
  logic signed [PW-1:0] dxa2_r, dya2_r, ra2_r, dxb2_r, dyb2_r, rb2_r;
  logic signed [PW-1:0] lx_r, ly_r, ox_r, oy_r, cp_r, cq_r;

  // Stage 4
  logic signed [SW-1:0] d2a_r, d2b_r, len_r, dot_r, cr_r;
  logic signed [PW-1:0] ra2b_r, rb2b_r;

  // Stage 5
  flg_t flg5_nxt, flg5_r, flg6_r, flg7_r;
  logic [MW-1:0] crmag_nxt, crmag_r, len5_r, r2_r;

  // Stage 6
  flg_t flg6_nxt;
  logic [2*H-1:0] c_hh_r, c_hl_r, c_ll_r;
  logic [2*H-1:0] p_hh_r, p_hl_r, p_lh_r, p_ll_r;

  // Stage 7
  logic [BW-1:0] c2_r, rl_r;

  // Stage 8
  logic in_ok, cs_hit, hit_nxt, hit8_r;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NS];
  assign out_hit   = hit8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: take the low coordinate bits and form corner sums
  assign fin = '{in_first_p0, in_first_p1, in_first_p2, in_first_p3};
  assign sin = '{in_second_p0, in_second_p1, in_second_p2, in_second_p3};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fext[i]  = 32'(fin[i]);
      sext[i]  = 32'(sin[i]);
      a_nxt[i] = $signed(fext[i][W-1:0]);
      b_nxt[i] = $signed(sext[i][W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      fn1_r  <= func_t'(in_func);
      ax1_r  <= sum_t'(a_nxt[0]) + sum_t'(a_nxt[2]);
      ay1_r  <= sum_t'(a_nxt[1]) + sum_t'(a_nxt[3]);
      bx1_r  <= sum_t'(b_nxt[0]) + sum_t'(b_nxt[2]);
      by1_r  <= sum_t'(b_nxt[1]) + sum_t'(b_nxt[3]);
      bxm_r  <= sum_t'(b_nxt[0]) - sum_t'(b_nxt[2]);
      bym_r  <= sum_t'(b_nxt[1]) - sum_t'(b_nxt[2]);
      byp_r  <= sum_t'(b_nxt[1]) + sum_t'(b_nxt[2]);
      rsum_r <= sum_t'(a_nxt[2]) + sum_t'(b_nxt[2]);
      rdif_r <= sum_t'(a_nxt[2]) - sum_t'(b_nxt[2]);
    end
  end

  // Stage 2: direct compares for the box tests
  always_comb begin
    rp0 = (sum_t'(b_r[0]) >= sum_t'(a_r[0])) && (sum_t'(b_r[0]) <= ax1_r) &&
          (sum_t'(b_r[1]) >= sum_t'(a_r[1])) && (sum_t'(b_r[1]) <= ay1_r);
    rp1 = (sum_t'(b_r[2]) >= sum_t'(a_r[0])) && (sum_t'(b_r[2]) <= ax1_r) &&
          (sum_t'(b_r[3]) >= sum_t'(a_r[1])) && (sum_t'(b_r[3]) <= ay1_r);
    case (fn1_r)
      FN_RR_OVL: begin
        dir_nxt = (sum_t'(a_r[0]) < bx1_r) && (ax1_r > sum_t'(b_r[0])) &&
                  (sum_t'(a_r[1]) < by1_r) && (ay1_r > sum_t'(b_r[1]));
      end
      FN_RS_OVL: dir_nxt = rp0 || rp1;
      FN_RP_OVL: dir_nxt = rp0;
      FN_RR_CON: begin
        dir_nxt = (b_r[0] >= a_r[0]) && (b_r[1] >= a_r[1]) &&
                  (bx1_r <= ax1_r) && (by1_r <= ay1_r);
      end
      FN_RC_CON: begin
        dir_nxt = (bxm_r >= sum_t'(a_r[0])) && (bx1_r <= ax1_r) &&
                  (bym_r >= sum_t'(a_r[1])) && (byp_r <= ay1_r);
      end
      FN_RS_CON: begin
        dir_nxt = (((b_r[0] < b_r[2]) ? b_r[0] : b_r[2]) >= a_r[0]) &&
                  (sum_t'((b_r[0] < b_r[2]) ? b_r[2] : b_r[0]) <= ax1_r) &&
                  (((b_r[1] < b_r[3]) ? b_r[1] : b_r[3]) >= a_r[1]) &&
                  (sum_t'((b_r[1] < b_r[3]) ? b_r[3] : b_r[1]) <= ay1_r);
      end
      FN_CC_CON: dir_nxt = (rdif_r >= 0);
      FN_RC_OVL, FN_CC_OVL, FN_CS_OVL, FN_CP_OVL, FN_SS_OVL,
      FN_CR_CON, FN_CS_CON: dir_nxt = 1'b1;
      default: dir_nxt = 1'b0;
    endcase
  end

  // Stage 2: clamp the circle center into the rect
  always_comb begin
    nx_t = (sum_t'(b_r[0]) < ax1_r) ? sum_t'(b_r[0]) : ax1_r;
    nx   = (nx_t > sum_t'(a_r[0])) ? nx_t : sum_t'(a_r[0]);
    ny_t = (sum_t'(b_r[1]) < ay1_r) ? sum_t'(b_r[1]) : ay1_r;
    ny   = (ny_t > sum_t'(a_r[1])) ? ny_t : sum_t'(a_r[1]);
  end

  // Stage 2: distance operands for the two radius checks
  always_comb begin
    dxa_nxt = opd_t'(a_r[0]) - opd_t'(b_r[0]);
    dya_nxt = opd_t'(a_r[1]) - opd_t'(b_r[1]);
    ra_nxt  = opd_t'(a_r[2]);
    dxb_nxt = opd_t'(a_r[0]) - opd_t'(b_r[2]);
    dyb_nxt = opd_t'(a_r[1]) - opd_t'(b_r[3]);
    rb_nxt  = opd_t'(a_r[2]);
    case (fn1_r)
      FN_RC_OVL: begin
        dxa_nxt = opd_t'(b_r[0]) - opd_t'(nx);
        dya_nxt = opd_t'(b_r[1]) - opd_t'(ny);
        ra_nxt  = opd_t'(b_r[2]);
      end
      FN_CC_OVL: ra_nxt = opd_t'(rsum_r);
      FN_CC_CON: ra_nxt = opd_t'(rdif_r);
      FN_CR_CON: begin
        dxb_nxt = opd_t'(bx1_r) - opd_t'(a_r[0]);
        dyb_nxt = opd_t'(by1_r) - opd_t'(a_r[1]);
      end
      default: ra_nxt = opd_t'(a_r[2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fn2_r  <= fn1_r;
      dir2_r <= dir_nxt;
      dxa_r  <= dxa_nxt;
      dya_r  <= dya_nxt;
      ra_r   <= ra_nxt;
      dxb_r  <= dxb_nxt;
      dyb_r  <= dyb_nxt;
      rb_r   <= rb_nxt;
      abx_r  <= opd_t'(b_r[2]) - opd_t'(b_r[0]);
      aby_r  <= opd_t'(b_r[3]) - opd_t'(b_r[1]);
      acx_r  <= opd_t'(a_r[0]) - opd_t'(b_r[0]);
      acy_r  <= opd_t'(a_r[1]) - opd_t'(b_r[1]);
    end
  end

  // Segment unit operands: unit 0 doubles as the segment-segment test
  always_comb begin
    for (int u = 0; u < 4; u++) begin
      sga[u][0] = opd_t'(b_r[0]);
      sga[u][1] = opd_t'(b_r[1]);
      sga[u][2] = opd_t'(b_r[2]);
      sga[u][3] = opd_t'(b_r[3]);
    end
    // bottom edge
    sga[0][4] = opd_t'(a_r[0]); sga[0][5] = opd_t'(a_r[1]);
    sga[0][6] = opd_t'(ax1_r);  sga[0][7] = opd_t'(a_r[1]);
    // top edge
    sga[1][4] = opd_t'(a_r[0]); sga[1][5] = opd_t'(ay1_r);
    sga[1][6] = opd_t'(ax1_r);  sga[1][7] = opd_t'(ay1_r);
    // left edge
    sga[2][4] = opd_t'(a_r[0]); sga[2][5] = opd_t'(a_r[1]);
    sga[2][6] = opd_t'(a_r[0]); sga[2][7] = opd_t'(ay1_r);
    // right edge
    sga[3][4] = opd_t'(ax1_r);  sga[3][5] = opd_t'(a_r[1]);
    sga[3][6] = opd_t'(ax1_r);  sga[3][7] = opd_t'(ay1_r);
    if (fn1_r == FN_SS_OVL) begin
      sga[0][0] = opd_t'(a_r[0]); sga[0][1] = opd_t'(a_r[1]);
      sga[0][2] = opd_t'(a_r[2]); sga[0][3] = opd_t'(a_r[3]);
      sga[0][4] = opd_t'(b_r[0]); sga[0][5] = opd_t'(b_r[1]);
      sga[0][6] = opd_t'(b_r[2]); sga[0][7] = opd_t'(b_r[3]);
    end
  end

  for (genvar u = 0; u < 4; u++) begin : g_seg
    spct_seg_unit #(.OW(OW)) u_seg (
      .clk (clk),
      .adv (en[5:2]),
      .ax  (sga[u][0]),
      .ay  (sga[u][1]),
      .bx  (sga[u][2]),
      .by  (sga[u][3]),
      .cx  (sga[u][4]),
      .cy  (sga[u][5]),
      .dx  (sga[u][6]),
      .dy  (sga[u][7]),
      .hit (seg_hit[u])
    );
  end

  // Stage 3: squares and dot/cross terms
  always_ff @(posedge clk) begin
    if (en[3]) begin
      fn3_r  <= fn2_r;
      dir3_r <= dir2_r;
      dxa2_r <= PW'(dxa_r) * PW'(dxa_r);
      dya2_r <= PW'(dya_r) * PW'(dya_r);
      ra2_r  <= PW'(ra_r) * PW'(ra_r);
      dxb2_r <= PW'(dxb_r) * PW'(dxb_r);
      dyb2_r <= PW'(dyb_r) * PW'(dyb_r);
      rb2_r  <= PW'(rb_r) * PW'(rb_r);
      lx_r   <= PW'(abx_r) * PW'(abx_r);
      ly_r   <= PW'(aby_r) * PW'(aby_r);
      ox_r   <= PW'(acx_r) * PW'(abx_r);
      oy_r   <= PW'(acy_r) * PW'(aby_r);
      cp_r   <= PW'(abx_r) * PW'(acy_r);
      cq_r   <= PW'(aby_r) * PW'(acx_r);
    end
  end

  // Stage 4: squared distances, segment length, dot and cross
  always_ff @(posedge clk) begin
    if (en[4]) begin
      fn4_r  <= fn3_r;
      dir4_r <= dir3_r;
      d2a_r  <= SW'(dxa2_r) + SW'(dya2_r);
      d2b_r  <= SW'(dxb2_r) + SW'(dyb2_r);
      ra2b_r <= ra2_r;
      rb2b_r <= rb2_r;
      len_r  <= SW'(lx_r) + SW'(ly_r);
      dot_r  <= SW'(ox_r) + SW'(oy_r);
      cr_r   <= SW'(cp_r) - SW'(cq_r);
    end
  end

  // Stage 5: radius checks and circle-segment region flags
  always_comb begin
    crmag_nxt      = cr_r[SW-1] ? MW'($unsigned(-cr_r)) : MW'($unsigned(cr_r));
    flg5_nxt.dir   = dir4_r;
    flg5_nxt.wa    = (d2a_r <= SW'(ra2b_r));
    flg5_nxt.wb    = (d2b_r <= SW'(rb2b_r));
    flg5_nxt.lenz  = (len_r == '0);
    flg5_nxt.dle0  = (dot_r <= 0);
    flg5_nxt.dge   = (dot_r >= len_r);
    flg5_nxt.crovf = ((crmag_nxt >> CROSS_LIMIT_BITS) != '0);
    flg5_nxt.seg   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fn5_r   <= fn4_r;
      flg5_r  <= flg5_nxt;
      crmag_r <= crmag_nxt;
      len5_r  <= MW'($unsigned(len_r));
      r2_r    <= MW'($unsigned(ra2b_r));
    end
  end

  // Stage 6: merge the segment results into the flags
  always_comb begin
    flg6_nxt     = flg5_r;
    flg6_nxt.seg = seg_hit;
  end

  // Stage 6: split the wide products into half-width partials
  always_ff @(posedge clk) begin
    if (en[6]) begin
      fn6_r  <= fn5_r;
      flg6_r <= flg6_nxt;
      c_hh_r <= (2*H)'(crmag_r[MW-1:H]) * (2*H)'(crmag_r[MW-1:H]);
      c_hl_r <= (2*H)'(crmag_r[MW-1:H]) * (2*H)'(crmag_r[H-1:0]);
      c_ll_r <= (2*H)'(crmag_r[H-1:0]) * (2*H)'(crmag_r[H-1:0]);
      p_hh_r <= (2*H)'(len5_r[MW-1:H]) * (2*H)'(r2_r[MW-1:H]);
      p_hl_r <= (2*H)'(len5_r[MW-1:H]) * (2*H)'(r2_r[H-1:0]);
      p_lh_r <= (2*H)'(len5_r[H-1:0]) * (2*H)'(r2_r[MW-1:H]);
      p_ll_r <= (2*H)'(len5_r[H-1:0]) * (2*H)'(r2_r[H-1:0]);
    end
  end

  // Stage 7: combine partials into cross squared and r squared times length
  always_ff @(posedge clk) begin
    if (en[7]) begin
      fn7_r  <= fn6_r;
      flg7_r <= flg6_r;
      c2_r   <= (BW'(c_hh_r) << (2*H)) + (BW'(c_hl_r) << (H+1)) + BW'(c_ll_r);
      rl_r   <= (BW'(p_hh_r) << (2*H)) + ((BW'(p_hl_r) + BW'(p_lh_r)) << H) +
                BW'(p_ll_r);
    end
  end

  // Stage 8: pick the answer for the selected test
  always_comb begin
    in_ok  = !flg7_r.crovf && (c2_r[CMPW-1:0] <= rl_r[CMPW-1:0]);
    cs_hit = (flg7_r.lenz || flg7_r.dle0) ? flg7_r.wa :
             (flg7_r.dge ? flg7_r.wb : in_ok);
    case (fn7_r)
      FN_RR_OVL, FN_RP_OVL, FN_RR_CON, FN_RC_CON, FN_RS_CON: hit_nxt = flg7_r.dir;
      FN_RC_OVL, FN_CC_OVL, FN_CP_OVL, FN_CC_CON: hit_nxt = flg7_r.dir && flg7_r.wa;
      FN_RS_OVL: hit_nxt = flg7_r.dir || (flg7_r.seg != '0);
      FN_CS_OVL: hit_nxt = cs_hit;
      FN_SS_OVL: hit_nxt = flg7_r.seg[0];
      FN_CR_CON, FN_CS_CON: hit_nxt = flg7_r.wa && flg7_r.wb;
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      fn8_r  <= fn7_r;
      hit8_r <= hit_nxt;
    end
  end

  // An empty output stage means the whole pipeline can take a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  // A result appears only from a word that sat in the stage before
  a_out_from_stage7: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v_r[NS-1]))
    else $error("result appeared without a word in flight");

  // Unused selector codes never report a hit
  a_unused_func_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (fn8_r > FN_CS_CON) |-> !out_hit)
    else $error("hit reported for an unused selector");

endmodule
